/* rtl/ufcc_pkg.sv */
// ufcc_pkg: shared types, codes and constants for the udp frame checksum checker
`timescale 1ns / 1ps

package ufcc_pkg;

    // frame size limit, bytes past it are dropped
    localparam logic [16:0] MAX_FRAME_BYTES = 17'd65536;

    // register map
    localparam logic [15:0] WATCHED_PORT_RESET = 16'd8888;
    localparam logic        REG_WATCHED_PORT   = 1'b0;

    // ethernet and ip codes
    localparam logic [15:0] ETH_IPV4   = 16'h0800;
    localparam logic [15:0] ETH_ARP    = 16'h0806;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;

    // frame class codes
    localparam logic [2:0] CLASS_UDP   = 3'd0;
    localparam logic [2:0] CLASS_TCP   = 3'd1;
    localparam logic [2:0] CLASS_ICMP  = 3'd2;
    localparam logic [2:0] CLASS_IPV4  = 3'd3;
    localparam logic [2:0] CLASS_ARP   = 3'd4;
    localparam logic [2:0] CLASS_OTHER = 3'd5;

    // checksum status codes
    localparam logic [1:0] STAT_NONE      = 2'd0;
    localparam logic [1:0] STAT_GOOD      = 2'd1;
    localparam logic [1:0] STAT_BAD       = 2'd2;
    localparam logic [1:0] STAT_MALFORMED = 2'd3;

    // command codes
    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_QUIT = 2'd1;
    localparam logic [1:0] CMD_JOIN = 2'd2;

    // command match flag bits
    localparam int FLAG_QUIT = 0;
    localparam int FLAG_JOIN = 1;

    // frame state captured at the last byte
    typedef struct packed {
        logic [15:0] ether_type;
        logic [3:0]  ihl;
        logic [7:0]  protocol;
        logic [31:0] ones_sum;
        logic [47:0] ports_len;
        logic [1:0]  cmd_flags;
        logic [16:0] frame_bytes;
    } snap_t;

    // one result
    typedef struct packed {
        logic [2:0]  frame_class;
        logic [15:0] ether_type;
        logic [7:0]  ip_protocol;
        logic [5:0]  ip_header_bytes;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [15:0] udp_length;
        logic [1:0]  checksum_status;
        logic        to_watched_port;
        logic [1:0]  command;
        logic [16:0] frame_bytes;
    } result_t;

    // "/quit" text
    function automatic logic [7:0] quit_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h2f;
            3'd1:    c = 8'h71;
            3'd2:    c = 8'h75;
            3'd3:    c = 8'h69;
            3'd4:    c = 8'h74;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "/join" text
    function automatic logic [7:0] join_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h2f;
            3'd1:    c = 8'h6a;
            3'd2:    c = 8'h6f;
            3'd3:    c = 8'h69;
            3'd4:    c = 8'h6e;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* rtl/ufcc_parser.sv */
// ufcc_parser: per-byte header capture, checksum accumulation and snapshot register
`timescale 1ns / 1ps

module ufcc_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  go,
    input  logic [7:0]            data_byte,
    input  logic                  last,
    output ufcc_pkg::snap_t       snap
);

    logic [16:0] pos_reg, pos_next;
    logic [15:0] et_reg, et_next;
    logic [3:0]  ihl_reg, ihl_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] sum_reg, sum_next;
    logic [47:0] ports_reg, ports_next;
    logic [1:0]  flags_reg, flags_next;
    ufcc_pkg::snap_t snap_reg, snap_next;

    logic        keep;
    logic [6:0]  seg_start;
    logic [16:0] rel;
    logic        in_seg;
    logic        add_ip;
    logic        add_seg;
    logic [15:0] word;
    logic [2:0]  cmd_idx;
    logic [15:0] len_now;

    always_comb
    begin
        keep      = pos_reg < ufcc_pkg::MAX_FRAME_BYTES;
        seg_start = 7'd14 + {1'b0, ihl_reg, 2'b00};
        rel       = pos_reg - {10'd0, seg_start};
        in_seg    = (pos_reg >= 17'd15) && (ihl_reg >= 4'd5) &&
                    (pos_reg >= {10'd0, seg_start});
        len_now   = ports_reg[15:0];
        word      = pos_reg[0] ? {8'd0, data_byte} : {data_byte, 8'd0};
        cmd_idx   = 3'(rel - 17'd8);

        pos_next   = pos_reg;
        et_next    = et_reg;
        ihl_next   = ihl_reg;
        proto_next = proto_reg;
        sum_next   = sum_reg;
        ports_next = ports_reg;
        flags_next = flags_reg;

        add_ip  = (pos_reg >= 17'd26) && (pos_reg <= 17'd33);
        add_seg = in_seg && ((rel < 17'd6) || (rel < {1'b0, len_now}));

        if (keep)
        begin
            pos_next = pos_reg + 17'd1;
            if (pos_reg == 17'd12 || pos_reg == 17'd13)
            begin
                et_next = {et_reg[7:0], data_byte};
            end
            else if (pos_reg == 17'd14)
            begin
                ihl_next = data_byte[3:0];
            end
            else if (pos_reg == 17'd23)
            begin
                proto_next = data_byte;
            end

            if (add_ip || add_seg)
            begin
                sum_next = sum_reg + {16'd0, word};
            end

            // udp header bytes, source port first
            for (int k = 0; k < 6; k++)
            begin
                if (in_seg && rel == 17'(k))
                begin
                    ports_next[8*(5-k) +: 8] = ports_reg[8*(5-k) +: 8] | data_byte;
                end
            end

            if (in_seg && rel >= 17'd8 && rel < 17'd13)
            begin
                if (data_byte != ufcc_pkg::quit_char(cmd_idx))
                begin
                    flags_next[ufcc_pkg::FLAG_QUIT] = 1'b0;
                end
                if (data_byte != ufcc_pkg::join_char(cmd_idx))
                begin
                    flags_next[ufcc_pkg::FLAG_JOIN] = 1'b0;
                end
            end
        end

        snap_next.ether_type  = et_next;
        snap_next.ihl         = ihl_next;
        snap_next.protocol    = proto_next;
        snap_next.ones_sum    = sum_next;
        snap_next.ports_len   = ports_next;
        snap_next.cmd_flags   = flags_next;
        snap_next.frame_bytes = pos_next;

        // per-frame state clears after the last byte
        if (last)
        begin
            pos_next   = '0;
            et_next    = '0;
            ihl_next   = '0;
            proto_next = '0;
            sum_next   = '0;
            ports_next = '0;
            flags_next = 2'b11;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            et_reg    <= '0;
            ihl_reg   <= '0;
            proto_reg <= '0;
            sum_reg   <= '0;
            ports_reg <= '0;
            flags_reg <= 2'b11;
        end
        else if (go)
        begin
            pos_reg   <= pos_next;
            et_reg    <= et_next;
            ihl_reg   <= ihl_next;
            proto_reg <= proto_next;
            sum_reg   <= sum_next;
            ports_reg <= ports_next;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && last)
        begin
            snap_reg <= snap_next;
        end
    end

    assign snap = snap_reg;

endmodule

/* rtl/ufcc_result.sv */
// ufcc_result: classification, checksum fold and command decode of a finished frame
`timescale 1ns / 1ps

module ufcc_result (
    input  ufcc_pkg::snap_t   snap,
    input  logic [15:0]       watched_port,
    output ufcc_pkg::result_t res
);

    logic        is_ip;
    logic        is_udp;
    logic [6:0]  seg_start;
    logic [15:0] sport, dport, len;
    logic [16:0] n;
    logic [16:0] hdr_end;
    logic [16:0] seg_end;
    logic [16:0] cmd_end;
    logic [31:0] total;
    logic [16:0] fold1;
    logic [16:0] fold2;
    logic        watched;

    always_comb
    begin
        is_ip     = snap.ether_type == ufcc_pkg::ETH_IPV4;
        is_udp    = is_ip && (snap.protocol == ufcc_pkg::PROTO_UDP);
        seg_start = 7'd14 + {1'b0, snap.ihl, 2'b00};
        sport     = snap.ports_len[47:32];
        dport     = snap.ports_len[31:16];
        len       = snap.ports_len[15:0];
        n         = snap.frame_bytes;
        hdr_end   = {10'd0, seg_start} + 17'd8;
        seg_end   = {10'd0, seg_start} + {1'b0, len};
        cmd_end   = {10'd0, seg_start} + 17'd13;

        // pseudo header adds protocol and udp length
        total = snap.ones_sum + 32'd17 + {16'd0, len};
        fold1 = {1'b0, total[31:16]} + {1'b0, total[15:0]};
        fold2 = fold1 + {16'd0, fold1[16]};

        watched = dport == watched_port;

        res                  = '0;
        res.ether_type       = snap.ether_type;
        res.frame_bytes      = n;
        res.checksum_status  = ufcc_pkg::STAT_NONE;
        res.command          = ufcc_pkg::CMD_NONE;

        if (is_ip)
        begin
            res.ip_protocol     = snap.protocol;
            res.ip_header_bytes = {snap.ihl, 2'b00};
            if (snap.protocol == ufcc_pkg::PROTO_UDP)
            begin
                res.frame_class = ufcc_pkg::CLASS_UDP;
            end
            else if (snap.protocol == ufcc_pkg::PROTO_TCP)
            begin
                res.frame_class = ufcc_pkg::CLASS_TCP;
            end
            else if (snap.protocol == ufcc_pkg::PROTO_ICMP)
            begin
                res.frame_class = ufcc_pkg::CLASS_ICMP;
            end
            else
            begin
                res.frame_class = ufcc_pkg::CLASS_IPV4;
            end
        end
        else if (snap.ether_type == ufcc_pkg::ETH_ARP)
        begin
            res.frame_class = ufcc_pkg::CLASS_ARP;
        end
        else
        begin
            res.frame_class = ufcc_pkg::CLASS_OTHER;
        end

        if (is_udp)
        begin
            if (snap.ihl < 4'd5)
            begin
                res.checksum_status = ufcc_pkg::STAT_MALFORMED;
            end
            else
            begin
                res.source_port      = sport;
                res.destination_port = dport;
                res.udp_length       = len;
                res.to_watched_port  = watched;
                if (n < hdr_end)
                begin
                    res.checksum_status = ufcc_pkg::STAT_MALFORMED;
                end
                else if (len <= 16'd8)
                begin
                    res.checksum_status = ufcc_pkg::STAT_NONE;
                end
                else if (n < seg_end)
                begin
                    res.checksum_status = ufcc_pkg::STAT_MALFORMED;
                end
                else if (fold2[15:0] == 16'hffff)
                begin
                    res.checksum_status = ufcc_pkg::STAT_GOOD;
                end
                else
                begin
                    res.checksum_status = ufcc_pkg::STAT_BAD;
                end

                if (watched && len >= 16'd13 && n >= cmd_end)
                begin
                    if (snap.cmd_flags[ufcc_pkg::FLAG_QUIT])
                    begin
                        res.command = ufcc_pkg::CMD_QUIT;
                    end
                    else if (snap.cmd_flags[ufcc_pkg::FLAG_JOIN])
                    begin
                        res.command = ufcc_pkg::CMD_JOIN;
                    end
                end
            end
        end
    end

endmodule

/* rtl/udp_frame_checksum_checker.sv */
// udp_frame_checksum_checker: top level, byte input stage, result register and apb register
`timescale 1ns / 1ps

// channel    direction  handshake           payload
// in         in         in_valid/in_ready   data_byte, last
// out        out        out_valid/out_ready frame_class .. frame_bytes (one per frame)
// apb        in         psel/penable/pready watched_port at byte address 0
//
// one byte per cycle unless stalled; results pass input, snapshot and result registers
// the last byte of a frame waits in the input register while the previous result
// still sits in the snapshot stage, so back-to-back one-byte frames can stall the input
// rst_n clears control state and sets watched_port to 8888
// out stalls hold the result register, then the snapshot stage, then a final byte in the input stage

module udp_frame_checksum_checker (
    input  logic        clk,
    input  logic        rst_n,
    // byte stream
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last,
    // frame results
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  frame_class,
    output logic [15:0] ether_type,
    output logic [7:0]  ip_protocol,
    output logic [5:0]  ip_header_bytes,
    output logic [15:0] source_port,
    output logic [15:0] destination_port,
    output logic [15:0] udp_length,
    output logic [1:0]  checksum_status,
    output logic        to_watched_port,
    output logic [1:0]  command,
    output logic [16:0] frame_bytes,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // input stage
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;
    logic        s1_go;

    // snapshot stage
    logic        s2_valid_reg, s2_valid_next;
    ufcc_pkg::snap_t snap;

    // result stage
    logic        out_valid_reg, out_valid_next;
    logic        out_load;
    ufcc_pkg::result_t res;
    ufcc_pkg::result_t res_reg;

    // register
    logic [15:0] watched_port_reg;
    logic        apb_write;

    // a non-final byte only updates frame state; a final byte needs the snapshot stage empty
    assign s1_go    = s1_valid_reg && (!s1_last_reg || !s2_valid_reg);
    assign in_ready = !s1_valid_reg || s1_go;
    assign out_load = s2_valid_reg && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // byte payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last;
        end
    end

    ufcc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (s1_go),
        .data_byte (s1_byte_reg),
        .last      (s1_last_reg),
        .snap      (snap)
    );

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (s1_go && s1_last_reg)
        begin
            s2_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s2_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // final checks of the captured frame
    ufcc_result u_result (
        .snap         (snap),
        .watched_port (watched_port_reg),
        .res          (res)
    );

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_reg <= res;
        end
    end

    // apb register, word index in paddr[2]
    assign apb_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            watched_port_reg <= ufcc_pkg::WATCHED_PORT_RESET;
        end
        else if (apb_write && paddr[2] == ufcc_pkg::REG_WATCHED_PORT)
        begin
            watched_port_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == ufcc_pkg::REG_WATCHED_PORT) ?
                    {16'd0, watched_port_reg} : 32'd0;

    // result ports
    assign out_valid        = out_valid_reg;
    assign frame_class      = res_reg.frame_class;
    assign ether_type       = res_reg.ether_type;
    assign ip_protocol      = res_reg.ip_protocol;
    assign ip_header_bytes  = res_reg.ip_header_bytes;
    assign source_port      = res_reg.source_port;
    assign destination_port = res_reg.destination_port;
    assign udp_length       = res_reg.udp_length;
    assign checksum_status  = res_reg.checksum_status;
    assign to_watched_port  = res_reg.to_watched_port;
    assign command          = res_reg.command;
    assign frame_bytes      = res_reg.frame_bytes;

endmodule

/* rtl/ufcc_checker.sv */
// ufcc_checker: port-level assertions for the udp frame checksum checker, with bind
`timescale 1ns / 1ps

module ufcc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  data_byte,
    input logic        last,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  frame_class,
    input logic [15:0] ether_type,
    input logic [7:0]  ip_protocol,
    input logic [5:0]  ip_header_bytes,
    input logic [15:0] source_port,
    input logic [15:0] destination_port,
    input logic [15:0] udp_length,
    input logic [1:0]  checksum_status,
    input logic        to_watched_port,
    input logic [1:0]  command,
    input logic [16:0] frame_bytes,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // a stalled result holds its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_bytes) &&
        $stable(checksum_status) && $stable(command) && $stable(destination_port))
        else $error("result changed while stalled");

    // only udp frames carry checksum, port match, udp length or command
    a_non_udp_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_class != ufcc_pkg::CLASS_UDP |->
        checksum_status == ufcc_pkg::STAT_NONE && !to_watched_port &&
        command == ufcc_pkg::CMD_NONE && udp_length == 16'd0)
        else $error("non-udp frame reports udp results");

    // a command needs the watched port and a full command text
    a_cmd_watched: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command != ufcc_pkg::CMD_NONE |->
        to_watched_port && udp_length >= 16'd13 && frame_bytes >= 17'd47)
        else $error("command without watched port or full payload");

    // every frame has at least one byte and never exceeds the limit
    a_frame_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frame_bytes != 17'd0 && frame_bytes <= ufcc_pkg::MAX_FRAME_BYTES)
        else $error("frame byte count out of range");

    // good or bad checksum needs the whole udp segment
    a_checked_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (checksum_status == ufcc_pkg::STAT_GOOD ||
        checksum_status == ufcc_pkg::STAT_BAD) |->
        udp_length > 16'd8 && frame_bytes >= 17'({1'b0, udp_length} + 17'd34))
        else $error("checksum judged on a short frame");

endmodule

bind udp_frame_checksum_checker ufcc_checker u_ufcc_checker (.*);
